// ----- src/oas_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and reset constants of the obstacle avoidance sequencer.
// Used by every module under src; depends on nothing else.
package oas_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 16;

  localparam logic [15:0] FWD_LIMIT_RST   = 16'd15000;
  localparam logic [15:0] CLEAR_WAIT_RST  = 16'd5000;
  localparam logic [15:0] TURN_LIMIT_RST  = 16'd3000;
  localparam logic [15:0] REV_LIMIT_RST   = 16'd5000;
  localparam logic        MUSIC_EN_RST    = 1'b1;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_WAIT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_LEFT  = 3'd4,
    MODE_REV   = 3'd5,
    MODE_STOP  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    MOTOR_STOP  = 3'd0,
    MOTOR_FWD   = 3'd1,
    MOTOR_RIGHT = 3'd2,
    MOTOR_LEFT  = 3'd3,
    MOTOR_REV   = 3'd4
  } motor_t;

  typedef enum logic [2:0] {
    LIGHT_OFF    = 3'd0,
    LIGHT_FWD    = 3'd1,
    LIGHT_SIDE   = 3'd2,
    LIGHT_REV    = 3'd3,
    LIGHT_HAZARD = 3'd4
  } light_t;

  typedef enum logic [2:0] {
    SOUND_SILENT = 3'd0,
    SOUND_MUSIC  = 3'd1,
    SOUND_HORN   = 3'd2,
    SOUND_BEEP   = 3'd3,
    SOUND_HAZARD = 3'd4
  } sound_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FWD_LIMIT  = 3'd0,
    CFG_CLEAR_WAIT = 3'd1,
    CFG_TURN_LIMIT = 3'd2,
    CFG_REV_LIMIT  = 3'd3,
    CFG_MUSIC_EN   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic        music_enable;
    logic [15:0] reverse_limit_ms;
    logic [15:0] turn_limit_ms;
    logic [15:0] clear_wait_ms;
    logic [15:0] forward_limit_ms;
  } cfg_t;

  // Front sensor sits in the lowest bit.
  typedef struct packed {
    logic rear_blocked;
    logic left_blocked;
    logic right_blocked;
    logic front_blocked;
  } sensors_t;

endpackage

// ----- src/oas_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the obstacle avoidance sequencer.
// Depends on oas_pkg for the register indexes and the cfg_t bundle.
module oas_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [oas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [oas_pkg::CFG_W-1:0]      cfg_wdata,
  output oas_pkg::cfg_t                  cfg
);

  oas_pkg::cfg_t cfg_r;
  oas_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (oas_pkg::cfg_index_t'(cfg_addr))
        oas_pkg::CFG_FWD_LIMIT:  cfg_nxt.forward_limit_ms = cfg_wdata;
        oas_pkg::CFG_CLEAR_WAIT: cfg_nxt.clear_wait_ms    = cfg_wdata;
        oas_pkg::CFG_TURN_LIMIT: cfg_nxt.turn_limit_ms    = cfg_wdata;
        oas_pkg::CFG_REV_LIMIT:  cfg_nxt.reverse_limit_ms = cfg_wdata;
        oas_pkg::CFG_MUSIC_EN:   cfg_nxt.music_enable     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.forward_limit_ms <= oas_pkg::FWD_LIMIT_RST;
      cfg_r.clear_wait_ms    <= oas_pkg::CLEAR_WAIT_RST;
      cfg_r.turn_limit_ms    <= oas_pkg::TURN_LIMIT_RST;
      cfg_r.reverse_limit_ms <= oas_pkg::REV_LIMIT_RST;
      cfg_r.music_enable     <= oas_pkg::MUSIC_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/oas_input_stage.sv -----
`timescale 1ns / 1ps
// Input register of the sequencer: captures one sensor tick per transfer.
// Depends on oas_pkg for the sensors_t layout.
module oas_input_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [oas_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           item_valid,
  input  logic                           item_ready,
  output oas_pkg::sensors_t              item_data
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  oas_pkg::sensors_t s1_data_r;
  logic              in_take;

  // The register frees up in the same cycle its content moves on.
  assign in_tready = !s1_valid_r || item_ready;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (item_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= oas_pkg::sensors_t'(in_tdata[3:0]);
    end
  end

  assign item_valid = s1_valid_r;
  assign item_data  = s1_data_r;

endmodule

// ----- src/oas_mode_core.sv -----
`timescale 1ns / 1ps
// Mode state, saturating millisecond timer, next-state logic and result register.
// Depends on oas_pkg for mode, motor, light and sound codes and the cfg_t bundle.
module oas_mode_core #(
  parameter int TIMER_BITS = oas_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  oas_pkg::cfg_t                   cfg,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  oas_pkg::sensors_t               item_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [oas_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef struct packed {
    oas_pkg::mode_t         mode;
    logic                   running;
    logic [TIMER_BITS-1:0]  elapsed;
    oas_pkg::motor_t        motor;
    oas_pkg::light_t        light;
    oas_pkg::sound_t        sound;
    logic                   rerun;
  } ev_t;

  // One evaluation of the mode logic. Entering a later case from an earlier
  // one is modeled by the go_* flags, checked in case order.
  function automatic ev_t mode_eval(ev_t s, oas_pkg::sensors_t sn, oas_pkg::cfg_t c);
    ev_t  n;
    logic go_wait;
    logic go_right;
    logic go_left;
    logic go_rev;
    logic go_stop;
    n        = s;
    n.rerun  = 1'b0;
    go_wait  = 1'b0;
    go_right = 1'b0;
    go_left  = 1'b0;
    go_rev   = 1'b0;
    go_stop  = 1'b0;
    case (s.mode)
      oas_pkg::MODE_START, oas_pkg::MODE_FWD: begin
        if (!sn.front_blocked) begin
          if (!n.running) begin
            n.motor   = oas_pkg::MOTOR_FWD;
            n.light   = oas_pkg::LIGHT_FWD;
            n.sound   = c.music_enable ? oas_pkg::SOUND_MUSIC : oas_pkg::SOUND_SILENT;
            n.running = 1'b1;
            n.mode    = oas_pkg::MODE_FWD;
          end
          if (CmpW'(n.elapsed) > CmpW'(c.forward_limit_ms)) begin
            n.motor   = oas_pkg::MOTOR_STOP;
            n.light   = oas_pkg::LIGHT_OFF;
            n.sound   = oas_pkg::SOUND_SILENT;
            n.running = 1'b0;
            n.mode    = oas_pkg::MODE_RIGHT;
          end
        end else begin
          n.elapsed = '0;
          n.motor   = oas_pkg::MOTOR_STOP;
          n.running = 1'b0;
          n.sound   = oas_pkg::SOUND_HORN;
          n.mode    = oas_pkg::MODE_WAIT;
          go_wait   = 1'b1;
        end
      end
      oas_pkg::MODE_WAIT:  go_wait  = 1'b1;
      oas_pkg::MODE_RIGHT: go_right = 1'b1;
      oas_pkg::MODE_LEFT:  go_left  = 1'b1;
      oas_pkg::MODE_REV:   go_rev   = 1'b1;
      default:             go_stop  = 1'b1;
    endcase

    if (go_wait) begin
      n.motor = oas_pkg::MOTOR_STOP;
      if (!sn.front_blocked) begin
        n.light = oas_pkg::LIGHT_OFF;
        n.sound = oas_pkg::SOUND_SILENT;
        n.mode  = oas_pkg::MODE_START;
        n.rerun = 1'b1;
      end else if (CmpW'(n.elapsed) < CmpW'(c.clear_wait_ms)) begin
        n.sound = oas_pkg::SOUND_HORN;
      end else begin
        n.light  = oas_pkg::LIGHT_OFF;
        n.sound  = oas_pkg::SOUND_SILENT;
        go_right = 1'b1;
      end
    end

    if (go_right) begin
      if (!sn.right_blocked) begin
        if (!n.running) begin
          n.motor   = oas_pkg::MOTOR_RIGHT;
          n.light   = oas_pkg::LIGHT_SIDE;
          n.sound   = oas_pkg::SOUND_SILENT;
          n.running = 1'b1;
          n.mode    = oas_pkg::MODE_RIGHT;
          n.elapsed = '0;
        end else if (CmpW'(n.elapsed) > CmpW'(c.turn_limit_ms)) begin
          n.running = 1'b0;
          n.light   = oas_pkg::LIGHT_OFF;
          n.sound   = oas_pkg::SOUND_SILENT;
          n.mode    = oas_pkg::MODE_START;
          n.rerun   = 1'b1;
        end
      end else begin
        n.running = 1'b0;
        n.light   = oas_pkg::LIGHT_OFF;
        go_left   = 1'b1;
      end
    end

    if (go_left) begin
      if (!sn.left_blocked) begin
        if (!n.running) begin
          n.motor   = oas_pkg::MOTOR_LEFT;
          n.light   = oas_pkg::LIGHT_SIDE;
          n.sound   = oas_pkg::SOUND_SILENT;
          n.running = 1'b1;
          n.mode    = oas_pkg::MODE_LEFT;
          n.elapsed = '0;
        end else if (CmpW'(n.elapsed) > CmpW'(c.turn_limit_ms)) begin
          n.running = 1'b0;
          n.light   = oas_pkg::LIGHT_OFF;
          n.sound   = oas_pkg::SOUND_SILENT;
          n.mode    = oas_pkg::MODE_START;
          n.rerun   = 1'b1;
        end
      end else begin
        n.running = 1'b0;
        n.light   = oas_pkg::LIGHT_OFF;
        go_rev    = 1'b1;
      end
    end

    if (go_rev) begin
      if (!sn.rear_blocked) begin
        if (!n.running) begin
          n.motor   = oas_pkg::MOTOR_REV;
          n.light   = oas_pkg::LIGHT_REV;
          n.sound   = oas_pkg::SOUND_BEEP;
          n.running = 1'b1;
          n.mode    = oas_pkg::MODE_REV;
          n.elapsed = '0;
        end else if (CmpW'(n.elapsed) > CmpW'(c.reverse_limit_ms)) begin
          n.running = 1'b0;
          n.light   = oas_pkg::LIGHT_OFF;
          n.sound   = oas_pkg::SOUND_SILENT;
          n.mode    = oas_pkg::MODE_START;
          n.rerun   = 1'b1;
        end
      end else begin
        n.running = 1'b0;
        n.light   = oas_pkg::LIGHT_OFF;
        n.sound   = oas_pkg::SOUND_SILENT;
        go_stop   = 1'b1;
      end
    end

    if (go_stop && !n.running) begin
      n.motor   = oas_pkg::MOTOR_STOP;
      n.light   = oas_pkg::LIGHT_HAZARD;
      n.sound   = oas_pkg::SOUND_HAZARD;
      n.mode    = oas_pkg::MODE_STOP;
      n.running = 1'b1;
    end
    return n;
  endfunction

  oas_pkg::mode_t        mode_r;
  logic                  running_r;
  logic [TIMER_BITS-1:0] elapsed_r;
  oas_pkg::motor_t       motor_r;
  oas_pkg::light_t       light_r;
  oas_pkg::sound_t       sound_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [oas_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                  take;
  logic [TIMER_BITS-1:0] elapsed_inc;
  ev_t                   pass0;
  ev_t                   pass1;
  ev_t                   pass2;
  ev_t                   ev_nxt;

  assign item_ready = !out_valid_r || out_tready;
  assign take       = item_valid && item_ready;

  assign elapsed_inc = (elapsed_r == {TIMER_BITS{1'b1}}) ? elapsed_r
                                                         : elapsed_r + 1'b1;

  always_comb begin
    pass0.mode    = mode_r;
    pass0.running = running_r;
    pass0.elapsed = elapsed_inc;
    pass0.motor   = motor_r;
    pass0.light   = light_r;
    pass0.sound   = sound_r;
    pass0.rerun   = 1'b0;
    pass1 = mode_eval(pass0, item_data, cfg);
    // A rerun always restarts from start mode with running clear, and that
    // evaluation never asks for another one, so two passes cover every case.
    pass2 = mode_eval(pass1, item_data, cfg);
    ev_nxt = pass1.rerun ? pass2 : pass1;
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= oas_pkg::MODE_START;
      running_r   <= 1'b0;
      elapsed_r   <= '0;
      motor_r     <= oas_pkg::MOTOR_STOP;
      light_r     <= oas_pkg::LIGHT_OFF;
      sound_r     <= oas_pkg::SOUND_SILENT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        mode_r    <= ev_nxt.mode;
        running_r <= ev_nxt.running;
        elapsed_r <= ev_nxt.elapsed;
        motor_r   <= ev_nxt.motor;
        light_r   <= ev_nxt.light;
        sound_r   <= ev_nxt.sound;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {4'b0000, ev_nxt.mode, ev_nxt.sound, ev_nxt.light, ev_nxt.motor};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/obstacle_avoidance_sequencer_core.sv -----
`timescale 1ns / 1ps
// Top level of the obstacle avoidance sequencer.
// Depends on oas_pkg, oas_cfg_regs, oas_input_stage and oas_mode_core.
//
//   Port group | Direction | Carries
//   in_*       | slave     | one sensor tick per transfer
//   out_*      | master    | one drive/light/sound/mode result per tick
//   cfg_*      | write     | limits and music enable, by register index
//
// One tick is accepted every clock while out_tready is high. The input
// register takes a tick at its transfer and the result register loads it when
// the core takes it from there; up to two chained next-state passes
// sit between the two registers. Reset is synchronous on rst_n low and puts
// the sequencer in start mode with the registers at their defaults. A low
// out_tready holds the result and backs up the input register behind it.
module obstacle_avoidance_sequencer_core #(
  parameter int TIMER_BITS = oas_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] front_blocked, [1] right_blocked, [2] left_blocked, [3] rear_blocked
  input  logic [oas_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] motor_command, [5:3] light_pattern, [8:6] sound_pattern, [11:9] mode_now
  output logic [oas_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [oas_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [oas_pkg::CFG_W-1:0]       cfg_wdata
);

  oas_pkg::cfg_t     cfg;
  logic              item_valid;
  logic              item_ready;
  oas_pkg::sensors_t item_data;

  oas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  oas_input_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data)
  );

  oas_mode_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Stopped for good means motor off with hazard lights and sound.
  a_stop_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11:9] == oas_pkg::MODE_STOP) |->
      (out_tdata[2:0] == oas_pkg::MOTOR_STOP && out_tdata[5:3] == oas_pkg::LIGHT_HAZARD
       && out_tdata[8:6] == oas_pkg::SOUND_HAZARD))
    else $error("stopped mode without hazard outputs");

  // Forward mode always drives forward with forward lights.
  a_fwd_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11:9] == oas_pkg::MODE_FWD) |->
      (out_tdata[2:0] == oas_pkg::MOTOR_FWD && out_tdata[5:3] == oas_pkg::LIGHT_FWD))
    else $error("forward mode with wrong motor or lights");

  // Waiting for the front to clear keeps the motor stopped and the horn on.
  a_wait_horn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11:9] == oas_pkg::MODE_WAIT) |->
      (out_tdata[2:0] == oas_pkg::MOTOR_STOP && out_tdata[8:6] == oas_pkg::SOUND_HORN))
    else $error("wait mode without stopped motor and horn");

endmodule

// ----- bench/obstacle_avoidance_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for obstacle_avoidance_sequencer_core.
// Predicts every result from its own copy of the mode logic; uses oas_pkg only.
module obstacle_avoidance_sequencer_core_tb;

  localparam int TIMER_W     = oas_pkg::TIMER_BITS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    oas_pkg::mode_t     mode;
    logic               running;
    logic [TIMER_W-1:0] elapsed;
    oas_pkg::motor_t    motor;
    oas_pkg::light_t    light;
    oas_pkg::sound_t    sound;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{oas_pkg::MODE_START, 1'b0, '0, oas_pkg::MOTOR_STOP,
                                       oas_pkg::LIGHT_OFF, oas_pkg::SOUND_SILENT};

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [oas_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [oas_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [oas_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [oas_pkg::CFG_W-1:0]       cfg_wdata = '0;

  obstacle_avoidance_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  oas_pkg::cfg_t     limits = '{oas_pkg::MUSIC_EN_RST, oas_pkg::REV_LIMIT_RST,
                                oas_pkg::TURN_LIMIT_RST, oas_pkg::CLEAR_WAIT_RST,
                                oas_pkg::FWD_LIMIT_RST};
  seq_state_t        plan_state = SEQ_RESET;   // advanced as ticks are queued
  seq_state_t        tick_model = SEQ_RESET;   // advanced as ticks are accepted
  oas_pkg::sensors_t pending_ticks[$];
  seq_state_t        expected_outputs[$];
  int                queued_count = 0;
  int                accepted_count = 0;
  int                checked_count = 0;
  int                error_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                allow_stop = 1'b0;
  bit                stop_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // One millisecond tick: bump the timer, then run the mode logic up to three
  // times, since a cleared front or a timeout sends it back through start.
  function automatic seq_state_t next_tick(seq_state_t s, oas_pkg::sensors_t sn,
                                           oas_pkg::cfg_t c);
    oas_pkg::mode_t stage;
    bit             again;
    bit             done;
    bit             blocked;
    if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
    for (int pass = 0; pass < 3; pass++) begin
      again = 1'b0;
      done  = 1'b0;
      stage = s.mode;
      while (!done) begin
        case (stage)
          oas_pkg::MODE_START, oas_pkg::MODE_FWD: begin
            if (!sn.front_blocked) begin
              if (!s.running) begin
                s.motor = oas_pkg::MOTOR_FWD;
                s.light = oas_pkg::LIGHT_FWD;
                if (c.music_enable) s.sound = oas_pkg::SOUND_MUSIC;
                else s.sound = oas_pkg::SOUND_SILENT;
                s.running = 1'b1;
                s.mode = oas_pkg::MODE_FWD;
              end
              if (s.elapsed > c.forward_limit_ms) begin
                s.motor = oas_pkg::MOTOR_STOP;
                s.light = oas_pkg::LIGHT_OFF;
                s.sound = oas_pkg::SOUND_SILENT;
                s.running = 1'b0;
                s.mode = oas_pkg::MODE_RIGHT;
              end
              done = 1'b1;
            end else begin
              s.elapsed = '0;
              s.motor = oas_pkg::MOTOR_STOP;
              s.running = 1'b0;
              s.sound = oas_pkg::SOUND_HORN;
              s.mode = oas_pkg::MODE_WAIT;
              stage = oas_pkg::MODE_WAIT;
            end
          end
          oas_pkg::MODE_WAIT: begin
            s.motor = oas_pkg::MOTOR_STOP;
            if (!sn.front_blocked) begin
              s.light = oas_pkg::LIGHT_OFF;
              s.sound = oas_pkg::SOUND_SILENT;
              s.mode = oas_pkg::MODE_START;
              again = 1'b1;
              done = 1'b1;
            end else if (s.elapsed < c.clear_wait_ms) begin
              s.sound = oas_pkg::SOUND_HORN;
              done = 1'b1;
            end else begin
              s.light = oas_pkg::LIGHT_OFF;
              s.sound = oas_pkg::SOUND_SILENT;
              stage = oas_pkg::MODE_RIGHT;
            end
          end
          oas_pkg::MODE_RIGHT, oas_pkg::MODE_LEFT: begin
            if (stage == oas_pkg::MODE_RIGHT) blocked = sn.right_blocked;
            else blocked = sn.left_blocked;
            if (!blocked) begin
              if (!s.running) begin
                if (stage == oas_pkg::MODE_RIGHT) s.motor = oas_pkg::MOTOR_RIGHT;
                else s.motor = oas_pkg::MOTOR_LEFT;
                s.light = oas_pkg::LIGHT_SIDE;
                s.sound = oas_pkg::SOUND_SILENT;
                s.running = 1'b1;
                s.mode = stage;
                s.elapsed = '0;
              end else if (s.elapsed > c.turn_limit_ms) begin
                s.running = 1'b0;
                s.light = oas_pkg::LIGHT_OFF;
                s.sound = oas_pkg::SOUND_SILENT;
                s.mode = oas_pkg::MODE_START;
                again = 1'b1;
              end
              done = 1'b1;
            end else begin
              s.running = 1'b0;
              s.light = oas_pkg::LIGHT_OFF;
              if (stage == oas_pkg::MODE_RIGHT) stage = oas_pkg::MODE_LEFT;
              else stage = oas_pkg::MODE_REV;
            end
          end
          oas_pkg::MODE_REV: begin
            if (!sn.rear_blocked) begin
              if (!s.running) begin
                s.motor = oas_pkg::MOTOR_REV;
                s.light = oas_pkg::LIGHT_REV;
                s.sound = oas_pkg::SOUND_BEEP;
                s.running = 1'b1;
                s.mode = oas_pkg::MODE_REV;
                s.elapsed = '0;
              end else if (s.elapsed > c.reverse_limit_ms) begin
                s.running = 1'b0;
                s.light = oas_pkg::LIGHT_OFF;
                s.sound = oas_pkg::SOUND_SILENT;
                s.mode = oas_pkg::MODE_START;
                again = 1'b1;
              end
              done = 1'b1;
            end else begin
              s.running = 1'b0;
              s.light = oas_pkg::LIGHT_OFF;
              s.sound = oas_pkg::SOUND_SILENT;
              stage = oas_pkg::MODE_STOP;
            end
          end
          default: begin
            if (!s.running) begin
              s.motor = oas_pkg::MOTOR_STOP;
              s.light = oas_pkg::LIGHT_HAZARD;
              s.sound = oas_pkg::SOUND_HAZARD;
              s.mode = oas_pkg::MODE_STOP;
              s.running = 1'b1;
            end
            done = 1'b1;
          end
        endcase
      end
      if (!again) break;
    end
    return s;
  endfunction

  // Stopped mode is left only by reset, so until the last phase a tick that
  // would end there gets a free rear instead.
  task automatic queue_tick(input oas_pkg::sensors_t sn);
    seq_state_t nxt;
    nxt = next_tick(plan_state, sn, limits);
    if (!allow_stop && nxt.mode == oas_pkg::MODE_STOP) begin
      sn.rear_blocked = 1'b0;
      nxt = next_tick(plan_state, sn, limits);
    end
    plan_state = nxt;
    pending_ticks.push_back(sn);
    queued_count++;
  endtask

  task automatic write_reg(input oas_pkg::cfg_index_t idx,
                           input logic [oas_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      oas_pkg::CFG_FWD_LIMIT:  limits.forward_limit_ms = val;
      oas_pkg::CFG_CLEAR_WAIT: limits.clear_wait_ms = val;
      oas_pkg::CFG_TURN_LIMIT: limits.turn_limit_ms = val;
      oas_pkg::CFG_REV_LIMIT:  limits.reverse_limit_ms = val;
      oas_pkg::CFG_MUSIC_EN:   limits.music_enable = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_limits(input logic [15:0] fwd, input logic [15:0] clr,
                              input logic [15:0] trn, input logic [15:0] rev,
                              input logic mus);
    write_reg(oas_pkg::CFG_FWD_LIMIT, fwd);
    write_reg(oas_pkg::CFG_CLEAR_WAIT, clr);
    write_reg(oas_pkg::CFG_TURN_LIMIT, trn);
    write_reg(oas_pkg::CFG_REV_LIMIT, rev);
    write_reg(oas_pkg::CFG_MUSIC_EN, {15'd0, mus});
    @(negedge clk);
  endtask

  // Mostly short limits so that timeouts happen, with the extremes now and then.
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic wait_drained();
    while (accepted_count != queued_count || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Obstacles persist for a while in practice, so most patterns are held for
  // several ticks; single ticks act as sensor noise.
  task automatic queue_random_ticks(input int count);
    oas_pkg::sensors_t sn;
    int                hold;
    int                made;
    made = 0;
    while (made < count) begin
      sn = oas_pkg::sensors_t'($urandom_range(0, 15));
      if ($urandom_range(0, 2) == 0) sn.front_blocked = 1'b0;
      if ($urandom_range(0, 4) == 0) hold = 1;
      else hold = $urandom_range(2, 24);
      repeat (hold) queue_tick(sn);
      made += hold;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [2:0] got,
                                 input logic [2:0] want);
    $display("mismatch on result %0d: %s got %0d, expected %0d",
             checked_count, field, got, want);
    error_count++;
  endtask

  task automatic check_result(input logic [oas_pkg::OUT_TDATA_W-1:0] data);
    seq_state_t want;
    if (expected_outputs.size() == 0) begin
      $display("result %0d arrived with nothing pending", checked_count);
      error_count++;
    end else begin
      want = expected_outputs.pop_front();
      if (data[2:0] != want.motor) report_mismatch("motor_command", data[2:0], want.motor);
      if (data[5:3] != want.light) report_mismatch("light_pattern", data[5:3], want.light);
      if (data[8:6] != want.sound) report_mismatch("sound_pattern", data[8:6], want.sound);
      if (data[11:9] != want.mode) report_mismatch("mode_now", data[11:9], want.mode);
      if (want.mode == oas_pkg::MODE_STOP) stop_seen = 1'b1;
    end
    checked_count++;
  endtask

  // Driver: the prediction is taken at the transfer, in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tick_model = next_tick(tick_model, oas_pkg::sensors_t'(in_tdata[3:0]), limits);
        expected_outputs.push_back(tick_model);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {4'd0, pending_ticks.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: start, horn while blocked, front cleared while waiting.
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    queue_tick(4'b0001);
    queue_tick(4'b0001);
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    wait_drained();

    // All limits zero, music off: immediate forward limit, zero clear wait,
    // turns that time out at once, right blocked into left into reverse.
    write_limits(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    queue_tick(4'b0001);
    queue_tick(4'b0011);
    queue_tick(4'b0111);
    queue_tick(4'b0000);
    queue_tick(4'b1110);
    wait_drained();

    // Short limits with music: each timeout returns through start.
    write_limits(16'd2, 16'd2, 16'd2, 16'd2, 1'b1);
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    queue_tick(4'b0000);
    queue_tick(4'b0010);
    queue_tick(4'b0010);
    queue_tick(4'b0001);
    queue_tick(4'b0001);
    queue_tick(4'b0111);
    queue_tick(4'b0111);
    queue_tick(4'b1000);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      write_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit(),
                   1'($urandom_range(0, 1)));
      queue_random_ticks(85);
      wait_drained();
    end

    // Last phase: everything blocked ends in stopped mode for good.
    send_idle_pct = 12;
    recv_stall_pct = 12;
    allow_stop = 1'b1;
    write_limits(16'd4, 16'd1, 16'd3, 16'd3, 1'b0);
    queue_tick(4'b0001);
    queue_tick(4'b0001);
    queue_tick(4'b1111);
    queue_tick(4'b1111);
    queue_random_ticks(12);
    wait_drained();
    repeat (10) @(negedge clk);

    if (expected_outputs.size() != 0) begin
      $display("%0d results never arrived", expected_outputs.size());
      error_count++;
    end
    $display("Checked %0d results for %0d sensor ticks, idle and stall phases included.",
             checked_count, accepted_count);
    $display("Limit extremes and timeouts exercised; stopped mode reached: %0d.", stop_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- obstacle_avoidance_sequencer_core.f -----
src/oas_pkg.sv
src/oas_cfg_regs.sv
src/oas_input_stage.sv
src/oas_mode_core.sv
src/obstacle_avoidance_sequencer_core.sv
bench/obstacle_avoidance_sequencer_core_tb.sv
